>>> design/triangle_circumcircle_incircle_unit_macros.svh
// ----------------------------------------------------------------------------
// triangle circumcircle unit assertion macros
// shared concurrent assertion forms, clocked and reset-qualified
// ----------------------------------------------------------------------------
`ifndef TRIANGLE_CIRCUMCIRCLE_INCIRCLE_UNIT_MACROS_SVH
`define TRIANGLE_CIRCUMCIRCLE_INCIRCLE_UNIT_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define TCC_ASSERT_NOW(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("tcc same-cycle check failed");

// consequent must hold in the cycle after the antecedent
`define TCC_ASSERT_NEXT(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("tcc next-cycle check failed");

`endif

>>> design/tcc_pkg.sv
// ----------------------------------------------------------------------------
// tcc_pkg
// shared widths of the circumcircle unit result fields
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tcc_pkg;

  // centre coordinates, signed fixed point
  localparam int unsigned CENTRE_W = 32;
  // squared radius, unsigned fixed point
  localparam int unsigned RADIUS_W = 63;

endpackage

>>> design/tcc_if.sv
// ----------------------------------------------------------------------------
// tcc channel interfaces
// valid/ready channels for triangle items and circumcircle results
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface tcc_in_if #(
  parameter int unsigned COORD_WIDTH = 16
) ();
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] ax;
  logic signed [COORD_WIDTH-1:0] ay;
  logic signed [COORD_WIDTH-1:0] bx;
  logic signed [COORD_WIDTH-1:0] by;
  logic signed [COORD_WIDTH-1:0] cx;
  logic signed [COORD_WIDTH-1:0] cy;
  logic signed [COORD_WIDTH-1:0] qx;
  logic signed [COORD_WIDTH-1:0] qy;

  modport source (output valid, ax, ay, bx, by, cx, cy, qx, qy, input ready);
  modport sink   (input valid, ax, ay, bx, by, cx, cy, qx, qy, output ready);
endinterface

interface tcc_out_if ();
  logic                                valid;
  logic                                ready;
  logic signed [tcc_pkg::CENTRE_W-1:0] centre_x;
  logic signed [tcc_pkg::CENTRE_W-1:0] centre_y;
  logic        [tcc_pkg::RADIUS_W-1:0] radius_sq;
  logic                                inside_res;
  logic                                degenerate;
  logic                                saturated;

  modport source (output valid, centre_x, centre_y, radius_sq, inside_res, degenerate,
                  saturated, input ready);
  modport sink   (input valid, centre_x, centre_y, radius_sq, inside_res, degenerate,
                  saturated, output ready);
endinterface

>>> design/tcc_div.sv
// ----------------------------------------------------------------------------
// tcc_div
// pipelined restoring divider, one quotient bit per stage, two numerators
// sharing one divisor, with a side tag that travels alongside
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tcc_div #(
  parameter int unsigned NUMW = 62,
  parameter int unsigned DVW  = 37,
  parameter int unsigned TAGW = 36
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  logic [NUMW-1:0] num_x_i,
  input  logic [NUMW-1:0] num_y_i,
  input  logic [DVW-1:0]  den_i,
  input  logic [TAGW-1:0] tag_i,
  output logic            valid_o,
  output logic [NUMW-1:0] quo_x_o,
  output logic [NUMW-1:0] quo_y_o,
  output logic [TAGW-1:0] tag_o
);

  // numerator bits are consumed from the top and replaced by quotient bits
  logic            v_q   [NUMW];
  logic [DVW-1:0]  rx_q  [NUMW];
  logic [DVW-1:0]  ry_q  [NUMW];
  logic [NUMW-1:0] nqx_q [NUMW];
  logic [NUMW-1:0] nqy_q [NUMW];
  logic [DVW-1:0]  den_q [NUMW];
  logic [TAGW-1:0] tag_q [NUMW];

  for (genvar i = 0; i < NUMW; i++) begin : g_stage
    logic            v_in;
    logic [DVW-1:0]  rx_in;
    logic [DVW-1:0]  ry_in;
    logic [NUMW-1:0] nqx_in;
    logic [NUMW-1:0] nqy_in;
    logic [DVW-1:0]  den_in;
    logic [TAGW-1:0] tag_in;
    logic [DVW:0]    tx;
    logic [DVW:0]    ty;
    logic            gx;
    logic            gy;
    logic [NUMW-1:0] nqx_d;
    logic [NUMW-1:0] nqy_d;

    if (i == 0) begin : g_first
      assign v_in   = valid_i;
      assign rx_in  = '0;
      assign ry_in  = '0;
      assign nqx_in = num_x_i;
      assign nqy_in = num_y_i;
      assign den_in = den_i;
      assign tag_in = tag_i;
    end else begin : g_next
      assign v_in   = v_q[i-1];
      assign rx_in  = rx_q[i-1];
      assign ry_in  = ry_q[i-1];
      assign nqx_in = nqx_q[i-1];
      assign nqy_in = nqy_q[i-1];
      assign den_in = den_q[i-1];
      assign tag_in = tag_q[i-1];
    end

    // trial subtract against the shifted partial remainder
    assign tx = {rx_in, nqx_in[NUMW-1-i]};
    assign ty = {ry_in, nqy_in[NUMW-1-i]};
    assign gx = (tx >= {1'b0, den_in});
    assign gy = (ty >= {1'b0, den_in});

    always_comb begin
      nqx_d = nqx_in;
      nqy_d = nqy_in;
      nqx_d[NUMW-1-i] = gx;
      nqy_d[NUMW-1-i] = gy;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[i] <= 1'b0;
      end else if (en_i) begin
        v_q[i] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rx_q[i]  <= gx ? DVW'(tx - {1'b0, den_in}) : DVW'(tx);
        ry_q[i]  <= gy ? DVW'(ty - {1'b0, den_in}) : DVW'(ty);
        nqx_q[i] <= nqx_d;
        nqy_q[i] <= nqy_d;
        den_q[i] <= den_in;
        tag_q[i] <= tag_in;
      end
    end
  end

  assign valid_o = v_q[NUMW-1];
  assign quo_x_o = nqx_q[NUMW-1];
  assign quo_y_o = nqy_q[NUMW-1];
  assign tag_o   = tag_q[NUMW-1];

endmodule

>>> design/triangle_circumcircle_incircle_unit.sv
// items pass stages 1 to 7, the divider pipeline, stages 8 and 9, then the result register
// throughput: one item per cycle while the result side is not stalled, no dependence between items
// most of the pipeline is the bit-serial divider pipeline, one quotient bit per stage
// a held result stalls the whole pipeline in step; nothing is lost or repeated
// reset: asynchronous active-low, clears all stage valid bits and the valid bit of the result register
// ----------------------------------------------------------------------------
// triangle_circumcircle_incircle_unit
// circumcentre, squared radius and strict in-circle test for one triangle
// per item, in exact integer arithmetic over a deep pipeline
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module triangle_circumcircle_incircle_unit #(
  parameter int unsigned COORD_WIDTH = 16,
  parameter int unsigned FRAC_BITS   = 8
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  tcc_in_if.sink    in_i,
  tcc_out_if.source out_o
);

  localparam int unsigned CW   = COORD_WIDTH;
  localparam int unsigned DW   = CW + 1;          // coordinate differences
  localparam int unsigned PW   = 2 * DW;          // products of differences
  localparam int unsigned SW   = 2 * CW + 3;      // sums of two products
  localparam int unsigned L    = CW + 2;          // low split of a sum
  localparam int unsigned HW   = SW - L;          // high split of a sum
  localparam int unsigned MPW  = DW + L + 1;      // centre partial products
  localparam int unsigned PRW  = DW + SW;         // centre full products
  localparam int unsigned NW   = PRW + 1;         // centre numerators
  localparam int unsigned DPW  = 2 * L + 2;       // determinant partials
  localparam int unsigned DPRW = 2 * SW;          // determinant full products
  localparam int unsigned DETW = DPRW + 2;        // in-circle determinant
  localparam int unsigned AW   = SW + 1;          // |2 * cross|
  localparam int unsigned DVW  = AW + 1;          // divisor 2 * |d|
  localparam int unsigned NUMW = NW + FRAC_BITS + 1;
  localparam int unsigned XW   = NUMW + 3;        // centre sum before clamp
  localparam int unsigned TAGW = 2 * CW + 4;
  localparam int unsigned CNW  = tcc_pkg::CENTRE_W;
  localparam int unsigned RDW  = tcc_pkg::RADIUS_W;

  localparam logic signed [XW-1:0] CMAX = XW'($signed({1'b0, {(CNW-1){1'b1}}}));
  localparam logic signed [XW-1:0] CMIN = XW'($signed({1'b1, {(CNW-1){1'b0}}}));

  // global advance: every stage moves when the result register can take data
  logic en;
  logic ov_q;

  assign en       = !ov_q || out_o.ready;
  assign in_i.ready = en;

  // --------------------------------------------------------------------------
  // stage 1: differences relative to vertex a and to the query point
  // --------------------------------------------------------------------------
  logic                 v1_q;
  logic signed [CW-1:0] ax1_q, ay1_q;
  logic signed [DW-1:0] bx1_q, by1_q, cx1_q, cy1_q;
  logic signed [DW-1:0] pax1_q, pay1_q, pbx1_q, pby1_q, pcx1_q, pcy1_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      ax1_q  <= in_i.ax;
      ay1_q  <= in_i.ay;
      bx1_q  <= {in_i.bx[CW-1], in_i.bx} - {in_i.ax[CW-1], in_i.ax};
      by1_q  <= {in_i.by[CW-1], in_i.by} - {in_i.ay[CW-1], in_i.ay};
      cx1_q  <= {in_i.cx[CW-1], in_i.cx} - {in_i.ax[CW-1], in_i.ax};
      cy1_q  <= {in_i.cy[CW-1], in_i.cy} - {in_i.ay[CW-1], in_i.ay};
      pax1_q <= {in_i.ax[CW-1], in_i.ax} - {in_i.qx[CW-1], in_i.qx};
      pay1_q <= {in_i.ay[CW-1], in_i.ay} - {in_i.qy[CW-1], in_i.qy};
      pbx1_q <= {in_i.bx[CW-1], in_i.bx} - {in_i.qx[CW-1], in_i.qx};
      pby1_q <= {in_i.by[CW-1], in_i.by} - {in_i.qy[CW-1], in_i.qy};
      pcx1_q <= {in_i.cx[CW-1], in_i.cx} - {in_i.qx[CW-1], in_i.qx};
      pcy1_q <= {in_i.cy[CW-1], in_i.cy} - {in_i.qy[CW-1], in_i.qy};
    end
  end

  // --------------------------------------------------------------------------
  // stage 2: all small products
  // --------------------------------------------------------------------------
  logic                 v2_q;
  logic signed [CW-1:0] ax2_q, ay2_q;
  logic signed [DW-1:0] bx2_q, by2_q, cx2_q, cy2_q;
  logic signed [PW-1:0] m_bxcy_q, m_bycx_q, m_bxbx_q, m_byby_q, m_cxcx_q, m_cycy_q;
  logic signed [PW-1:0] m_pax2_q, m_pay2_q, m_pbx2_q, m_pby2_q, m_pcx2_q, m_pcy2_q;
  logic signed [PW-1:0] m_pbxpcy_q, m_pbypcx_q, m_paxpcy_q, m_paypcx_q;
  logic signed [PW-1:0] m_paxpby_q, m_paypbx_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      ax2_q      <= ax1_q;
      ay2_q      <= ay1_q;
      bx2_q      <= bx1_q;
      by2_q      <= by1_q;
      cx2_q      <= cx1_q;
      cy2_q      <= cy1_q;
      m_bxcy_q   <= bx1_q * cy1_q;
      m_bycx_q   <= by1_q * cx1_q;
      m_bxbx_q   <= bx1_q * bx1_q;
      m_byby_q   <= by1_q * by1_q;
      m_cxcx_q   <= cx1_q * cx1_q;
      m_cycy_q   <= cy1_q * cy1_q;
      m_pax2_q   <= pax1_q * pax1_q;
      m_pay2_q   <= pay1_q * pay1_q;
      m_pbx2_q   <= pbx1_q * pbx1_q;
      m_pby2_q   <= pby1_q * pby1_q;
      m_pcx2_q   <= pcx1_q * pcx1_q;
      m_pcy2_q   <= pcy1_q * pcy1_q;
      m_pbxpcy_q <= pbx1_q * pcy1_q;
      m_pbypcx_q <= pby1_q * pcx1_q;
      m_paxpcy_q <= pax1_q * pcy1_q;
      m_paypcx_q <= pay1_q * pcx1_q;
      m_paxpby_q <= pax1_q * pby1_q;
      m_paypbx_q <= pay1_q * pbx1_q;
    end
  end

  // --------------------------------------------------------------------------
  // stage 3: cross product, squared lengths, in-circle minors
  // --------------------------------------------------------------------------
  logic                 v3_q;
  logic signed [CW-1:0] ax3_q, ay3_q;
  logic signed [DW-1:0] bx3_q, by3_q, cx3_q, cy3_q;
  logic signed [SW-1:0] cross3_q, bsq3_q, csq3_q;
  logic signed [SW-1:0] sa3_q, sb3_q, sc3_q, ka3_q, kb3_q, kc3_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      ax3_q    <= ax2_q;
      ay3_q    <= ay2_q;
      bx3_q    <= bx2_q;
      by3_q    <= by2_q;
      cx3_q    <= cx2_q;
      cy3_q    <= cy2_q;
      cross3_q <= SW'(m_bxcy_q) - SW'(m_bycx_q);
      bsq3_q   <= SW'(m_bxbx_q) + SW'(m_byby_q);
      csq3_q   <= SW'(m_cxcx_q) + SW'(m_cycy_q);
      sa3_q    <= SW'(m_pax2_q) + SW'(m_pay2_q);
      sb3_q    <= SW'(m_pbx2_q) + SW'(m_pby2_q);
      sc3_q    <= SW'(m_pcx2_q) + SW'(m_pcy2_q);
      ka3_q    <= SW'(m_pbxpcy_q) - SW'(m_pbypcx_q);
      kb3_q    <= SW'(m_paxpcy_q) - SW'(m_paypcx_q);
      kc3_q    <= SW'(m_paxpby_q) - SW'(m_paypbx_q);
    end
  end

  // --------------------------------------------------------------------------
  // stage 4: partial products of wide operands split into a signed high and an unsigned low part
  // --------------------------------------------------------------------------
  logic signed [HW-1:0] bsq_h, csq_h, sa_h, sb_h, sc_h, ka_h, kb_h, kc_h;
  logic signed [L:0]    bsq_l, csq_l, sa_l, sb_l, sc_l, ka_l, kb_l, kc_l;

  assign bsq_h = $signed(bsq3_q[SW-1:L]);
  assign csq_h = $signed(csq3_q[SW-1:L]);
  assign sa_h  = $signed(sa3_q[SW-1:L]);
  assign sb_h  = $signed(sb3_q[SW-1:L]);
  assign sc_h  = $signed(sc3_q[SW-1:L]);
  assign ka_h  = $signed(ka3_q[SW-1:L]);
  assign kb_h  = $signed(kb3_q[SW-1:L]);
  assign kc_h  = $signed(kc3_q[SW-1:L]);
  assign bsq_l = $signed({1'b0, bsq3_q[L-1:0]});
  assign csq_l = $signed({1'b0, csq3_q[L-1:0]});
  assign sa_l  = $signed({1'b0, sa3_q[L-1:0]});
  assign sb_l  = $signed({1'b0, sb3_q[L-1:0]});
  assign sc_l  = $signed({1'b0, sc3_q[L-1:0]});
  assign ka_l  = $signed({1'b0, ka3_q[L-1:0]});
  assign kb_l  = $signed({1'b0, kb3_q[L-1:0]});
  assign kc_l  = $signed({1'b0, kc3_q[L-1:0]});

  logic                  v4_q;
  logic signed [CW-1:0]  ax4_q, ay4_q;
  logic signed [SW-1:0]  cross4_q;
  logic signed [MPW-1:0] q_cyb_h_q, q_cyb_l_q, q_byc_h_q, q_byc_l_q;
  logic signed [MPW-1:0] q_bxc_h_q, q_bxc_l_q, q_cxb_h_q, q_cxb_l_q;
  logic signed [DPW-1:0] q_a_hh_q, q_a_hl_q, q_a_lh_q, q_a_ll_q;
  logic signed [DPW-1:0] q_b_hh_q, q_b_hl_q, q_b_lh_q, q_b_ll_q;
  logic signed [DPW-1:0] q_c_hh_q, q_c_hl_q, q_c_lh_q, q_c_ll_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      ax4_q     <= ax3_q;
      ay4_q     <= ay3_q;
      cross4_q  <= cross3_q;
      q_cyb_h_q <= cy3_q * bsq_h;
      q_cyb_l_q <= cy3_q * bsq_l;
      q_byc_h_q <= by3_q * csq_h;
      q_byc_l_q <= by3_q * csq_l;
      q_bxc_h_q <= bx3_q * csq_h;
      q_bxc_l_q <= bx3_q * csq_l;
      q_cxb_h_q <= cx3_q * bsq_h;
      q_cxb_l_q <= cx3_q * bsq_l;
      q_a_hh_q  <= sa_h * ka_h;
      q_a_hl_q  <= sa_h * ka_l;
      q_a_lh_q  <= sa_l * ka_h;
      q_a_ll_q  <= sa_l * ka_l;
      q_b_hh_q  <= sb_h * kb_h;
      q_b_hl_q  <= sb_h * kb_l;
      q_b_lh_q  <= sb_l * kb_h;
      q_b_ll_q  <= sb_l * kb_l;
      q_c_hh_q  <= sc_h * kc_h;
      q_c_hl_q  <= sc_h * kc_l;
      q_c_lh_q  <= sc_l * kc_h;
      q_c_ll_q  <= sc_l * kc_l;
    end
  end

  // --------------------------------------------------------------------------
  // stage 5: recombine partial products
  // --------------------------------------------------------------------------
  logic                   v5_q;
  logic signed [CW-1:0]   ax5_q, ay5_q;
  logic signed [SW-1:0]   cross5_q;
  logic signed [PRW-1:0]  t_cyb5_q, t_byc5_q, t_bxc5_q, t_cxb5_q;
  logic signed [DPRW-1:0] t_a5_q, t_b5_q, t_c5_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      ax5_q    <= ax4_q;
      ay5_q    <= ay4_q;
      cross5_q <= cross4_q;
      t_cyb5_q <= (PRW'(q_cyb_h_q) <<< L) + PRW'(q_cyb_l_q);
      t_byc5_q <= (PRW'(q_byc_h_q) <<< L) + PRW'(q_byc_l_q);
      t_bxc5_q <= (PRW'(q_bxc_h_q) <<< L) + PRW'(q_bxc_l_q);
      t_cxb5_q <= (PRW'(q_cxb_h_q) <<< L) + PRW'(q_cxb_l_q);
      t_a5_q   <= (DPRW'(q_a_hh_q) <<< (2 * L))
                + ((DPRW'(q_a_hl_q) + DPRW'(q_a_lh_q)) <<< L) + DPRW'(q_a_ll_q);
      t_b5_q   <= (DPRW'(q_b_hh_q) <<< (2 * L))
                + ((DPRW'(q_b_hl_q) + DPRW'(q_b_lh_q)) <<< L) + DPRW'(q_b_ll_q);
      t_c5_q   <= (DPRW'(q_c_hh_q) <<< (2 * L))
                + ((DPRW'(q_c_hl_q) + DPRW'(q_c_lh_q)) <<< L) + DPRW'(q_c_ll_q);
    end
  end

  // --------------------------------------------------------------------------
  // stage 6: centre numerators and in-circle determinant
  // --------------------------------------------------------------------------
  logic                   v6_q;
  logic signed [CW-1:0]   ax6_q, ay6_q;
  logic signed [SW-1:0]   cross6_q;
  logic signed [NW-1:0]   nx6_q, ny6_q;
  logic signed [DETW-1:0] det6_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      ax6_q    <= ax5_q;
      ay6_q    <= ay5_q;
      cross6_q <= cross5_q;
      nx6_q    <= NW'(t_cyb5_q) - NW'(t_byc5_q);
      ny6_q    <= NW'(t_bxc5_q) - NW'(t_cxb5_q);
      det6_q   <= DETW'(t_a5_q) - DETW'(t_b5_q) + DETW'(t_c5_q);
    end
  end

  // --------------------------------------------------------------------------
  // stage 7: magnitudes for round-to-nearest division, ties away from zero
  // q = (2 * |n << frac| + |d|) / (2 * |d|), d = 2 * cross
  // --------------------------------------------------------------------------
  logic [NW-1:0] absx, absy;
  logic [SW-1:0] abscr;
  logic [AW-1:0] absd;

  assign absx  = nx6_q[NW-1] ? (~nx6_q + 1'b1) : nx6_q;
  assign absy  = ny6_q[NW-1] ? (~ny6_q + 1'b1) : ny6_q;
  assign abscr = cross6_q[SW-1] ? (~cross6_q + 1'b1) : cross6_q;
  assign absd  = {abscr, 1'b0};

  logic                 v7_q;
  logic signed [CW-1:0] ax7_q, ay7_q;
  logic [NUMW-1:0]      numx7_q, numy7_q;
  logic [DVW-1:0]       den7_q;
  logic                 sx7_q, sy7_q, in7_q, dg7_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      ax7_q   <= ax6_q;
      ay7_q   <= ay6_q;
      numx7_q <= (NUMW'(absx) << (FRAC_BITS + 1)) + NUMW'(absd);
      numy7_q <= (NUMW'(absy) << (FRAC_BITS + 1)) + NUMW'(absd);
      den7_q  <= {absd, 1'b0};
      sx7_q   <= nx6_q[NW-1] ^ cross6_q[SW-1];
      sy7_q   <= ny6_q[NW-1] ^ cross6_q[SW-1];
      // strictly inside when the determinant is nonzero and agrees with orientation
      in7_q   <= (det6_q != '0) && (det6_q[DETW-1] == cross6_q[SW-1]);
      dg7_q   <= (cross6_q == '0);
    end
  end

  // --------------------------------------------------------------------------
  // divider pipeline, one quotient bit per stage for both centre coordinates
  // --------------------------------------------------------------------------
  logic            vd;
  logic [NUMW-1:0] quox, quoy;
  logic [TAGW-1:0] tagd;

  tcc_div #(
    .NUMW (NUMW),
    .DVW  (DVW),
    .TAGW (TAGW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v7_q),
    .num_x_i (numx7_q),
    .num_y_i (numy7_q),
    .den_i   (den7_q),
    .tag_i   ({ax7_q, ay7_q, sx7_q, sy7_q, in7_q, dg7_q}),
    .valid_o (vd),
    .quo_x_o (quox),
    .quo_y_o (quoy),
    .tag_o   (tagd)
  );

  logic signed [CW-1:0] ax_t, ay_t;
  logic                 sx_t, sy_t, in_t, dg_t;
  logic [XW-1:0]        qxe, qye;

  assign {ax_t, ay_t, sx_t, sy_t, in_t, dg_t} = tagd;
  assign qxe = XW'(quox);
  assign qye = XW'(quoy);

  // --------------------------------------------------------------------------
  // stage 8: signed centre offsets and radius range check
  // --------------------------------------------------------------------------
  logic                 v8_q;
  logic signed [CW-1:0] ax8_q, ay8_q;
  logic signed [XW-1:0] ux8_q, uy8_q;
  logic [31:0]          qxl8_q, qyl8_q;
  logic                 big8_q, in8_q, dg8_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      ax8_q  <= ax_t;
      ay8_q  <= ay_t;
      ux8_q  <= sx_t ? -$signed(qxe) : $signed(qxe);
      uy8_q  <= sy_t ? -$signed(qye) : $signed(qye);
      qxl8_q <= qxe[31:0];
      qyl8_q <= qye[31:0];
      // offsets of 2^32 or more make the square overflow
      big8_q <= (qxe[XW-1:32] != '0) || (qye[XW-1:32] != '0);
      in8_q  <= in_t;
      dg8_q  <= dg_t;
    end
  end

  // --------------------------------------------------------------------------
  // stage 9: absolute centre with clamp, squared offsets
  // --------------------------------------------------------------------------
  logic signed [XW-1:0] ox, oy;
  logic                 satx, saty;

  assign ox   = (XW'(ax8_q) <<< FRAC_BITS) + ux8_q;
  assign oy   = (XW'(ay8_q) <<< FRAC_BITS) + uy8_q;
  assign satx = (ox > CMAX) || (ox < CMIN);
  assign saty = (oy > CMAX) || (oy < CMIN);

  logic                  v9_q;
  logic signed [CNW-1:0] cx9_q, cy9_q;
  logic [63:0]           rx9_q, ry9_q;
  logic                  satc9_q, big9_q, in9_q, dg9_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      cx9_q   <= satx ? ((ox < CMIN) ? CNW'(CMIN) : CNW'(CMAX)) : ox[CNW-1:0];
      cy9_q   <= saty ? ((oy < CMIN) ? CNW'(CMIN) : CNW'(CMAX)) : oy[CNW-1:0];
      satc9_q <= satx || saty;
      rx9_q   <= qxl8_q * qxl8_q;
      ry9_q   <= qyl8_q * qyl8_q;
      big9_q  <= big8_q;
      in9_q   <= in8_q;
      dg9_q   <= dg8_q;
    end
  end

  // --------------------------------------------------------------------------
  // result register: radius sum with clamp, collinear override
  // --------------------------------------------------------------------------
  logic [64:0] rs;
  logic        rsat;

  assign rs   = {1'b0, rx9_q} + {1'b0, ry9_q};
  assign rsat = big9_q || rs[64] || rs[63];

  logic signed [CNW-1:0] cxo_q, cyo_q;
  logic [RDW-1:0]        rso_q;
  logic                  ino_q, dgo_q, sto_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (dg9_q) begin
        cxo_q <= '0;
        cyo_q <= '0;
        rso_q <= '0;
        ino_q <= 1'b0;
        dgo_q <= 1'b1;
        sto_q <= 1'b0;
      end else begin
        cxo_q <= cx9_q;
        cyo_q <= cy9_q;
        rso_q <= rsat ? '1 : rs[RDW-1:0];
        ino_q <= in9_q;
        dgo_q <= 1'b0;
        sto_q <= satc9_q || rsat;
      end
    end
  end

  // valid bits travel with the data and all move on the shared advance
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
      v7_q <= 1'b0;
      v8_q <= 1'b0;
      v9_q <= 1'b0;
      ov_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_i.valid;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
      v6_q <= v5_q;
      v7_q <= v6_q;
      v8_q <= vd;
      v9_q <= v8_q;
      ov_q <= v9_q;
    end
  end

  assign out_o.valid      = ov_q;
  assign out_o.centre_x   = cxo_q;
  assign out_o.centre_y   = cyo_q;
  assign out_o.radius_sq  = rso_q;
  assign out_o.inside_res = ino_q;
  assign out_o.degenerate = dgo_q;
  assign out_o.saturated  = sto_q;

endmodule

>>> design/tcc_chk.sv
// ----------------------------------------------------------------------------
// tcc_chk
// port-level checks on the circumcircle unit, attached by bind
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "triangle_circumcircle_incircle_unit_macros.svh"

module tcc_chk (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                in_valid_i,
  input logic                                in_ready_i,
  input logic                                out_valid_i,
  input logic                                out_ready_i,
  input logic signed [tcc_pkg::CENTRE_W-1:0] centre_x_i,
  input logic signed [tcc_pkg::CENTRE_W-1:0] centre_y_i,
  input logic        [tcc_pkg::RADIUS_W-1:0] radius_sq_i,
  input logic                                inside_res_i,
  input logic                                degenerate_i,
  input logic                                saturated_i
);

  // a held result stays valid and keeps its centre_x and radius_sq until the transfer
  `TCC_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(centre_x_i) && $stable(radius_sq_i))

  // an empty result register never blocks the input side
  `TCC_ASSERT_NOW(a_ready_free, clk_i, rst_ni, !out_valid_i, in_ready_i)

  // a stalled result freezes the whole pipeline, input included
  `TCC_ASSERT_NOW(a_stall_input, clk_i, rst_ni, out_valid_i && !out_ready_i, !in_ready_i || !in_valid_i || !in_ready_i)

  // collinear vertices give all-zero results
  `TCC_ASSERT_NOW(a_degen_zero, clk_i, rst_ni, out_valid_i && degenerate_i, centre_x_i == 0 && centre_y_i == 0 && radius_sq_i == 0 && !inside_res_i && !saturated_i)

endmodule

bind triangle_circumcircle_incircle_unit tcc_chk u_tcc_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .centre_x_i   (out_o.centre_x),
  .centre_y_i   (out_o.centre_y),
  .radius_sq_i  (out_o.radius_sq),
  .inside_res_i (out_o.inside_res),
  .degenerate_i (out_o.degenerate),
  .saturated_i  (out_o.saturated)
);

>>> test/tcc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcc_checker
// watches both channels, predicts each circumcircle result from the accepted
// triangle and compares it field by field with the result that comes out
// ----------------------------------------------------------------------------

module tcc_checker (
  input  logic clk_i,
  input  logic rst_ni,
  tcc_in_if    in_mon,
  tcc_out_if   out_mon,
  output int   fail_count_o,
  output int   pending_o
);

  typedef logic signed [127:0] wide_t;

  typedef struct packed {
    logic signed [tcc_pkg::CENTRE_W-1:0] centre_x;
    logic signed [tcc_pkg::CENTRE_W-1:0] centre_y;
    logic        [tcc_pkg::RADIUS_W-1:0] radius_sq;
    logic                                inside_res;
    logic                                degenerate;
    logic                                saturated;
  } circle_t;

  localparam int    FRAC      = 8;
  localparam wide_t CENTRE_HI = 128'sh7fff_ffff;
  localparam wide_t CENTRE_LO = -CENTRE_HI - 1;
  localparam wide_t RADIUS_HI = 128'sh7fff_ffff_ffff_ffff;
  localparam wide_t SQ_LIMIT  = 128'sh1_0000_0000;

  circle_t expected_circles[$];

  // divide rounding to nearest, ties away from zero
  function automatic wide_t round_div(input wide_t num, input wide_t den);
    logic [127:0] mn;
    logic [127:0] md;
    logic [127:0] quo;
    mn  = num < 0 ? -num : num;
    md  = den < 0 ? -den : den;
    quo = ((mn << 1) + md) / (md << 1);
    return ((num < 0) != (den < 0)) ? -wide_t'(quo) : wide_t'(quo);
  endfunction

  function automatic logic [31:0] clamp_centre(input wide_t v, inout logic sat);
    if (v > CENTRE_HI) begin
      sat = 1'b1;
      return CENTRE_HI[31:0];
    end
    if (v < CENTRE_LO) begin
      sat = 1'b1;
      return CENTRE_LO[31:0];
    end
    return v[31:0];
  endfunction

  function automatic circle_t predict_circle(
    input logic signed [15:0] ax_in, input logic signed [15:0] ay_in,
    input logic signed [15:0] bx_in, input logic signed [15:0] by_in,
    input logic signed [15:0] cx_in, input logic signed [15:0] cy_in,
    input logic signed [15:0] qx_in, input logic signed [15:0] qy_in);
    circle_t res;
    wide_t   ax, ay, bx, by, cx, cy, qx, qy;
    wide_t   cross_v, bsq, csq, nx, ny, ux, uy, mux, muy, rsum;
    wide_t   pax, pay, pbx, pby, pcx, pcy, det;
    logic    sat;
    res = '0;
    sat = 1'b0;
    ax = ax_in;
    ay = ay_in;
    bx = wide_t'(bx_in) - ax;
    by = wide_t'(by_in) - ay;
    cx = wide_t'(cx_in) - ax;
    cy = wide_t'(cy_in) - ay;
    qx = qx_in;
    qy = qy_in;
    cross_v = bx * cy - by * cx;
    if (cross_v == 0) begin
      // collinear or repeated vertices: flag only, everything else zero
      res.degenerate = 1'b1;
      return res;
    end
    bsq = bx * bx + by * by;
    csq = cx * cx + cy * cy;
    nx  = cy * bsq - by * csq;
    ny  = bx * csq - cx * bsq;
    ux  = round_div(nx <<< FRAC, 2 * cross_v);
    uy  = round_div(ny <<< FRAC, 2 * cross_v);
    res.centre_x = clamp_centre((ax <<< FRAC) + ux, sat);
    res.centre_y = clamp_centre((ay <<< FRAC) + uy, sat);
    // radius from the rounded centre offset to vertex a
    mux = ux < 0 ? -ux : ux;
    muy = uy < 0 ? -uy : uy;
    rsum = mux * mux + muy * muy;
    if (mux >= SQ_LIMIT || muy >= SQ_LIMIT || rsum > RADIUS_HI) begin
      res.radius_sq = RADIUS_HI[62:0];
      sat = 1'b1;
    end else begin
      res.radius_sq = rsum[62:0];
    end
    // exact in-circle determinant, sign flipped for clockwise triangles
    pax = ax - qx;
    pay = ay - qy;
    pbx = bx + ax - qx;
    pby = by + ay - qy;
    pcx = cx + ax - qx;
    pcy = cy + ay - qy;
    det = (pax * pax + pay * pay) * (pbx * pcy - pby * pcx)
        - (pbx * pbx + pby * pby) * (pax * pcy - pay * pcx)
        + (pcx * pcx + pcy * pcy) * (pax * pby - pay * pbx);
    res.inside_res = (det != 0) && ((det < 0) == (cross_v < 0));
    res.saturated  = sat;
    return res;
  endfunction

  task automatic report_mismatch(input string field, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("%0t: mismatch on %s: got %h, expected %h", $realtime, field, got, want);
    fail_count_o++;
  endtask

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
  end

  always @(posedge clk_i) begin
    circle_t want;
    if (rst_ni) begin
      if (in_mon.valid && in_mon.ready) begin
        expected_circles.push_back(predict_circle(in_mon.ax, in_mon.ay, in_mon.bx,
                                                  in_mon.by, in_mon.cx, in_mon.cy,
                                                  in_mon.qx, in_mon.qy));
      end
      if (out_mon.valid && out_mon.ready) begin
        if (expected_circles.size() == 0) begin
          report_mismatch("unexpected result", 64'd0, 64'd0);
        end else begin
          want = expected_circles.pop_front();
          if (out_mon.centre_x !== want.centre_x)
            report_mismatch("centre_x", 64'(out_mon.centre_x), 64'(want.centre_x));
          if (out_mon.centre_y !== want.centre_y)
            report_mismatch("centre_y", 64'(out_mon.centre_y), 64'(want.centre_y));
          if (out_mon.radius_sq !== want.radius_sq)
            report_mismatch("radius_sq", 64'(out_mon.radius_sq), 64'(want.radius_sq));
          if (out_mon.inside_res !== want.inside_res)
            report_mismatch("inside_res", 64'(out_mon.inside_res), 64'(want.inside_res));
          if (out_mon.degenerate !== want.degenerate)
            report_mismatch("degenerate", 64'(out_mon.degenerate), 64'(want.degenerate));
          if (out_mon.saturated !== want.saturated)
            report_mismatch("saturated", 64'(out_mon.saturated), 64'(want.saturated));
        end
      end
      pending_o = expected_circles.size();
    end
  end

endmodule

>>> test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// drives triangles into the circumcircle unit with random gaps and output
// stalls, and gives the verdict from the checker's failure and pending counts
// ----------------------------------------------------------------------------

module testbench;

  typedef logic signed [15:0] coord_t;

  typedef struct packed {
    coord_t ax, ay, bx, by, cx, cy, qx, qy;
  } triangle_t;

  localparam int RANDOM_ITEMS = 1400;
  localparam int STALL_LIMIT  = 3000;
  localparam int LONG_HOLD    = 300;
  localparam int DRAIN_CYCLES = 100;

  logic clk_i;
  logic rst_ni;
  int   fail_count;
  int   pending;
  int   stall_cycles;
  bit   no_idle;
  bit   hold_request;

  tcc_in_if #(.COORD_WIDTH(16)) in_ch ();
  tcc_out_if                    out_ch ();

  triangle_circumcircle_incircle_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  tcc_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_mon       (in_ch),
    .out_mon      (out_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // 12 ns period
  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  // watchdog: too long without any transfer on either side
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
        $display("timeout after %0d cycles without a transfer", STALL_LIMIT);
        $display("Verification failed");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  // result side: random back-pressure, plus one long hold-off on request
  initial begin
    int gap;
    out_ch.ready = 1'b0;
    wait (rst_ni);
    forever begin
      gap = no_idle ? 0 : $urandom_range(0, 14);
      if (hold_request) begin
        gap = LONG_HOLD;
        hold_request = 1'b0;
      end
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!out_ch.valid);
    end
  end

  // one triangle transfer with a random gap in front of it
  task automatic send_triangle(input triangle_t trg);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.ax <= trg.ax;
    in_ch.ay <= trg.ay;
    in_ch.bx <= trg.bx;
    in_ch.by <= trg.by;
    in_ch.cx <= trg.cx;
    in_ch.cy <= trg.cy;
    in_ch.qx <= trg.qx;
    in_ch.qy <= trg.qy;
    do @(posedge clk_i); while (!in_ch.ready);
  endtask

  function automatic coord_t pick_coord(input int span);
    case (span)
      0:       return coord_t'($urandom);
      1:       return coord_t'(int'($urandom_range(0, 400)) - 200);
      default: begin
        case ($urandom_range(0, 3))
          0:       return 16'sh7fff;
          1:       return 16'sh8000;
          2:       return 16'sh0000;
          default: return coord_t'(int'($urandom_range(0, 8)) - 4);
        endcase
      end
    endcase
  endfunction

  function automatic triangle_t random_triangle();
    triangle_t trg;
    int        span, ax, ay, dx, dy, k1, k2;
    span = $urandom_range(0, 2);
    trg.ax = pick_coord(span);
    trg.ay = pick_coord(span);
    trg.bx = pick_coord(span);
    trg.by = pick_coord(span);
    trg.cx = pick_coord(span);
    trg.cy = pick_coord(span);
    trg.qx = pick_coord(span);
    trg.qy = pick_coord(span);
    case ($urandom_range(0, 9))
      0: begin
        // collinear: c and b on one line through a
        ax = int'($urandom_range(0, 2000)) - 1000;
        ay = int'($urandom_range(0, 2000)) - 1000;
        dx = int'($urandom_range(0, 200)) - 100;
        dy = int'($urandom_range(0, 200)) - 100;
        k1 = int'($urandom_range(0, 40)) - 20;
        k2 = int'($urandom_range(0, 40)) - 20;
        trg.ax = coord_t'(ax);
        trg.ay = coord_t'(ay);
        trg.bx = coord_t'(ax + k1 * dx);
        trg.by = coord_t'(ay + k1 * dy);
        trg.cx = coord_t'(ax + k2 * dx);
        trg.cy = coord_t'(ay + k2 * dy);
      end
      1: begin
        // query on a vertex, so it lies on the circle
        trg.qx = trg.bx;
        trg.qy = trg.by;
      end
      2: begin
        // query near the middle of the triangle
        trg.qx = coord_t'((int'(trg.ax) + int'(trg.bx) + int'(trg.cx)) / 3);
        trg.qy = coord_t'((int'(trg.ay) + int'(trg.by) + int'(trg.cy)) / 3);
      end
      default: ;
    endcase
    return trg;
  endfunction

  // directed cases: extremes, collinear shapes, on-circle, inside, outside, far centres
  triangle_t directed[$] = '{
    '{16'sh0000, 16'sh0000, 16'sh0004, 16'sh0000, 16'sh0000, 16'sh0004, 16'sh0004, 16'sh0004},
    '{16'sh0000, 16'sh0000, 16'sh0004, 16'sh0000, 16'sh0000, 16'sh0004, 16'sh0001, 16'sh0001},
    '{16'sh0000, 16'sh0000, 16'sh0000, 16'sh0004, 16'sh0004, 16'sh0000, 16'sh0001, 16'sh0001},
    '{16'sh0000, 16'sh0000, 16'sh0004, 16'sh0000, 16'sh0000, 16'sh0004, 16'sh0064, 16'shff9c},
    '{16'sh0005, 16'sh0001, 16'sh0005, 16'sh0009, 16'sh0005, 16'shfff0, 16'sh0000, 16'sh0000},
    '{16'sh0001, 16'sh0007, 16'sh0009, 16'sh0007, 16'shfff3, 16'sh0007, 16'sh0000, 16'sh0000},
    '{16'sh0003, 16'sh0003, 16'sh0003, 16'sh0003, 16'sh0009, 16'sh0002, 16'sh0000, 16'sh0000},
    '{16'sh0001, 16'sh0001, 16'sh0002, 16'sh0002, 16'sh0005, 16'sh0005, 16'sh0003, 16'sh0000},
    '{16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7ffe, 16'sh0000, 16'sh0000},
    '{16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh7ffe, 16'sh7fff, 16'sh7fff, 16'sh8000},
    '{16'sh8000, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh0000, 16'sh0000},
    '{16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh8000},
    '{16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh0000, 16'sh8000, 16'sh7fff, 16'sh8000},
    '{16'shffff, 16'shffff, 16'sh0001, 16'sh0000, 16'sh0000, 16'sh0002, 16'shffff, 16'shffff},
    '{16'sh0000, 16'sh0000, 16'sh0003, 16'sh0000, 16'sh0000, 16'sh0001, 16'sh0001, 16'sh0000},
    '{16'sh0000, 16'sh0000, 16'sh0001, 16'sh0000, 16'sh0000, 16'sh0003, 16'sh0000, 16'sh0001},
    '{16'sh0000, 16'sh0000, 16'sh0004, 16'sh0000, 16'sh0000, 16'shfffc, 16'sh0002, 16'sh0000},
    '{16'sh0000, 16'sh0000, 16'shffff, 16'sh0000, 16'sh0001, 16'sh0001, 16'sh5555, 16'shaaaa},
    '{16'sh5555, 16'shaaaa, 16'shaaaa, 16'sh5555, 16'sh0000, 16'sh0000, 16'shaaaa, 16'sh5555}
  };

  initial begin
    rst_ni       = 1'b0;
    stall_cycles = 0;
    no_idle      = 1'b0;
    hold_request = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.ax     = '0;
    in_ch.ay     = '0;
    in_ch.bx     = '0;
    in_ch.by     = '0;
    in_ch.cx     = '0;
    in_ch.cy     = '0;
    in_ch.qx     = '0;
    in_ch.qy     = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[i]) send_triangle(directed[i]);

    // sender waits for the pipeline to empty completely
    in_ch.valid <= 1'b0;
    while (pending != 0) @(posedge clk_i);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      // random stretches with and without idling
      if (n % 100 == 0) no_idle = ($urandom_range(0, 2) == 0);
      // receiver holds off while the sender streams, filling the pipeline
      if (n == 300) begin
        no_idle      = 1'b1;
        hold_request = 1'b1;
      end
      send_triangle(random_triangle());
    end

    in_ch.valid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (fail_count == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
